@@ hdl/rrg_pkg.sv @@
// Shared types and constants for the rational reduction unit.
// No dependencies; imported by rrg_divider and rational_reduce_gcd_unit.
`default_nettype none

package rrg_pkg;

  // Port field width and internal datapath width (low DATA_WIDTH bits are used).
  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [FIELD_W-1:0]    field_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD_TEST,
    S_GCD_WAIT,
    S_DIVN_WAIT,
    S_DIVD_WAIT,
    S_DIVW_WAIT,
    S_FIN
  } state_e;

  // Sign-extend one datapath word to port width.
  function automatic field_t sext_field(input word_t x);
    sext_field = FIELD_W'(signed'(x));
  endfunction

  // Magnitude of a two's complement word, as an unsigned word.
  function automatic word_t mag(input word_t x);
    mag = x[DATA_WIDTH-1] ? (word_t'(0) - x) : x;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rrg_divider.sv @@
// Bit-serial truncating signed divider: one quotient bit per cycle.
// Depends on rrg_pkg.
`default_nettype none

module rrg_divider import rrg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t dividend_i,
  input  word_t divisor_i,
  output logic  done_o,
  output word_t quo_o,
  output word_t rem_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  word_t            rem_q, quo_q, dvs_q, a_q;
  logic             neg_a_q, neg_q, zero_q;

  logic [DATA_WIDTH:0] shifted, diff;
  logic                take;

  // Restoring step: shift in the next dividend bit, trial-subtract the divisor.
  always_comb begin
    shifted = {rem_q, quo_q[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    take    = ~diff[DATA_WIDTH];
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(DATA_WIDTH);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= dividend_i;
      neg_a_q <= dividend_i[DATA_WIDTH-1];
      neg_q   <= dividend_i[DATA_WIDTH-1] ^ divisor_i[DATA_WIDTH-1];
      zero_q  <= (divisor_i == '0);
      quo_q   <= mag(dividend_i);
      dvs_q   <= mag(divisor_i);
      rem_q   <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_q <= {quo_q[DATA_WIDTH-2:0], take};
    end
  end

  // Restore signs; a zero divisor gives quotient 0 and passes the dividend.
  always_comb begin
    if (zero_q) begin
      quo_o = '0;
      rem_o = a_q;
    end else begin
      quo_o = neg_q   ? (word_t'(0) - quo_q) : quo_q;
      rem_o = neg_a_q ? (word_t'(0) - rem_q) : rem_q;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

@@ hdl/rational_reduce_gcd_unit.sv @@
// Top level: reduces a signed fraction by its Euclidean divisor and splits it.
// Depends on rrg_pkg and rrg_divider.
`default_nettype none

// Channel | Beat content                                    | Handshake
// --------+-------------------------------------------------+-------------------------
// in      | numer_in_i, denom_in_i                          | in_valid_i / in_stall_o
// out     | whole_part_o, rem_numer_o, reduced_denom_o,     | out_valid_o / out_stall_i
//         | common_divisor_o                                |
//
// One shared bit-serial divider does all the work. Each Euclid step passes through
// S_GCD_TEST before its division, and an item takes K + 3 divisions in all, K being the
// number of Euclid steps (up to about 92 at 64 bits); a zero denominator takes no
// division. A stalled output holds the finished item in S_FIN until it can be loaded.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the
// output register. An input beat is taken only while the sequencer is idle; a
// result held by out_stall_i stays put while the next input beat is taken.

module rational_reduce_gcd_unit import rrg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  field_t numer_in_i,
  input  field_t denom_in_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output field_t whole_part_o,
  output field_t rem_numer_o,
  output field_t reduced_denom_o,
  output field_t common_divisor_o
);

  state_e state_q, state_d;

  // Working registers: original/reduced fraction, Euclid pair, divisor and whole part.
  word_t num_q, num_d;
  word_t den_q, den_d;
  word_t n_q, n_d;
  word_t r_q, r_d;
  word_t g_q, g_d;
  word_t whole_q, whole_d;

  // Output register.
  logic   out_valid_q, out_valid_d;
  field_t whole_out_q, rem_out_q, den_out_q, gcd_out_q;
  logic   out_load;

  // Divider hookup.
  logic  div_start;
  word_t div_a, div_b;
  logic  div_done;
  word_t div_quo, div_rem;

  rrg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    den_d       = den_q;
    n_d         = n_q;
    r_d         = r_q;
    g_d         = g_q;
    whole_d     = whole_q;
    div_start   = 1'b0;
    div_a       = n_q;
    div_b       = r_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;

    case (state_q)
      S_IDLE: begin
        // Take a beat: seed the Euclid loop with the denominator as divisor.
        if (in_valid_i) begin
          num_d   = numer_in_i[DATA_WIDTH-1:0];
          den_d   = denom_in_i[DATA_WIDTH-1:0];
          n_d     = numer_in_i[DATA_WIDTH-1:0];
          r_d     = denom_in_i[DATA_WIDTH-1:0];
          g_d     = '0;
          whole_d = '0;
          state_d = S_GCD_TEST;
        end
      end
      S_GCD_TEST: begin
        if (r_q != '0) begin
          // Next Euclid step: remainder of n by r.
          g_d       = r_q;
          div_start = 1'b1;
          div_a     = n_q;
          div_b     = r_q;
          state_d   = S_GCD_WAIT;
        end else if (g_q == '0) begin
          // Zero denominator: pass the fraction through, whole part stays 0.
          state_d = S_FIN;
        end else begin
          div_start = 1'b1;
          div_a     = num_q;
          div_b     = g_q;
          state_d   = S_DIVN_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (div_done) begin
          n_d     = g_q;
          r_d     = div_rem;
          state_d = S_GCD_TEST;
        end
      end
      S_DIVN_WAIT: begin
        // Reduced numerator in; chain straight into denominator / divisor.
        if (div_done) begin
          num_d     = div_quo;
          div_start = 1'b1;
          div_a     = den_q;
          div_b     = g_q;
          state_d   = S_DIVD_WAIT;
        end
      end
      S_DIVD_WAIT: begin
        // Reduced denominator in; split the reduced fraction.
        if (div_done) begin
          den_d     = div_quo;
          div_start = 1'b1;
          div_a     = num_q;
          div_b     = div_quo;
          state_d   = S_DIVW_WAIT;
        end
      end
      S_DIVW_WAIT: begin
        if (div_done) begin
          whole_d = div_quo;
          num_d   = div_rem;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hand off once the output register is empty or being drained.
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    n_q     <= n_d;
    r_q     <= r_d;
    g_q     <= g_d;
    whole_q <= whole_d;
    if (out_load) begin
      whole_out_q <= sext_field(whole_q);
      rem_out_q   <= sext_field(num_q);
      den_out_q   <= sext_field(den_q);
      gcd_out_q   <= sext_field(g_q);
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign whole_part_o     = whole_out_q;
  assign rem_numer_o      = rem_out_q;
  assign reduced_denom_o  = den_out_q;
  assign common_divisor_o = gcd_out_q;

endmodule

`default_nettype wire

@@ tb/rational_reduce_gcd_unit_tb.sv @@
// Self-checking testbench for rational_reduce_gcd_unit: directed table, then random fractions.
// Depends on rrg_pkg and the RTL of rational_reduce_gcd_unit; reads no files.
module rational_reduce_gcd_unit_tb;
  import rrg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One reduced fraction as it leaves the block.
  typedef struct packed {
    field_t whole_part;
    field_t rem_numer;
    field_t reduced_denom;
    field_t common_divisor;
  } reduced_t;

  // One row of the directed table. Rows with typed_in set carry their own result;
  // the rest are checked against reduce_fraction().
  typedef struct packed {
    field_t   numer;
    field_t   denom;
    logic     typed_in;
    reduced_t res;
  } stim_row_t;

  localparam field_t MOST_NEG  = 64'h8000_0000_0000_0000;
  localparam field_t MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam field_t MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  // Consecutive Fibonacci numbers: the longest Euclid run that fits in 64 bits.
  localparam field_t FIB_92    = 64'd7540113804746346429;
  localparam field_t FIB_91    = 64'd4660046610375530309;
  localparam reduced_t NO_RESULT = '0;

  // Worst item: about 95 divisions.
  localparam int unsigned ITEM_CYCLES_MAX = 95 * (DATA_WIDTH + 2) + 3;
  localparam int unsigned WATCHDOG_LIMIT  = 4 * ITEM_CYCLES_MAX + 1000;
  localparam int unsigned ITEMS_PER_PHASE = 360;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned NUM_DIRECTED    = 25;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // zero denominator: pass through, no divisor
    '{64'd12345, 64'd0, 1'b1, '{64'd0, 64'd12345, 64'd0, 64'd0}},
    '{MOST_NEG,  64'd0, 1'b1, '{64'd0, MOST_NEG,  64'd0, 64'd0}},
    '{MINUS_ONE, 64'd0, 1'b1, '{64'd0, MINUS_ONE, 64'd0, 64'd0}},
    '{64'd0,     64'd0, 1'b1, '{64'd0, 64'd0,     64'd0, 64'd0}},
    // most negative over minus one wraps back to most negative
    '{MOST_NEG,  MINUS_ONE, 1'b1, '{MOST_NEG, 64'd0, 64'd1, MINUS_ONE}},
    '{MOST_NEG,  MOST_NEG,  1'b1, '{64'd1,    64'd0, 64'd1, MOST_NEG}},
    '{MOST_POS,  64'd1,     1'b1, '{MOST_POS, 64'd0, 64'd1, 64'd1}},
    // zero numerator: divisor is the denominator itself, sign kept
    '{64'd0,     64'd5,     1'b1, '{64'd0, 64'd0, 64'd1, 64'd5}},
    '{64'd0,     -64'sd7,   1'b1, '{64'd0, 64'd0, 64'd1, -64'sd7}},
    '{64'd6,     64'd4,     1'b1, '{64'd1, 64'd1, 64'd2, 64'd2}},
    '{MOST_POS,  MOST_NEG,  1'b0, NO_RESULT},
    '{MOST_NEG,  MOST_POS,  1'b0, NO_RESULT},
    '{MINUS_ONE, MINUS_ONE, 1'b0, NO_RESULT},
    '{64'd1,     MOST_NEG,  1'b0, NO_RESULT},
    '{MOST_NEG,  64'd1,     1'b0, NO_RESULT},
    '{-64'sd6,   64'd4,     1'b0, NO_RESULT},
    '{64'd6,     -64'sd4,   1'b0, NO_RESULT},
    '{-64'sd6,   -64'sd4,   1'b0, NO_RESULT},
    '{-64'sd7,   64'd3,     1'b0, NO_RESULT},
    '{FIB_92,    FIB_91,    1'b0, NO_RESULT},
    '{-FIB_92,   FIB_91,    1'b0, NO_RESULT},
    '{FIB_91,    -FIB_92,   1'b0, NO_RESULT},
    '{64'd123000000861, 64'd456000003192, 1'b0, NO_RESULT},
    '{MOST_POS,  MOST_POS,  1'b0, NO_RESULT},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RESULT}
  };

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  field_t numer_in_i  = '0;
  field_t denom_in_i  = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  field_t whole_part_o;
  field_t rem_numer_o;
  field_t reduced_denom_o;
  field_t common_divisor_o;

  // Reductions still owed by the block, oldest first.
  reduced_t    awaited_reductions[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct  = 36;
  int unsigned rx_idle_pct  = 59;

  rational_reduce_gcd_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .numer_in_i       (numer_in_i),
    .denom_in_i       (denom_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .whole_part_o     (whole_part_o),
    .rem_numer_o      (rem_numer_o),
    .reduced_denom_o  (reduced_denom_o),
    .common_divisor_o (common_divisor_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: truncating signed arithmetic at DATA_WIDTH bits.
  // ---------------------------------------------------------------------------

  function automatic word_t abs_word(input word_t x);
    return x[DATA_WIDTH-1] ? ('0 - x) : x;
  endfunction

  // Quotient truncated toward zero; a zero divisor gives zero.
  function automatic word_t trunc_quot(input word_t a, input word_t b);
    word_t q;
    if (b == '0) return '0;
    q = abs_word(a) / abs_word(b);
    return (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? ('0 - q) : q;
  endfunction

  // Remainder with the sign of the dividend; a zero divisor returns the dividend.
  function automatic word_t trunc_rem(input word_t a, input word_t b);
    word_t r;
    if (b == '0) return a;
    r = abs_word(a) % abs_word(b);
    return a[DATA_WIDTH-1] ? ('0 - r) : r;
  endfunction

  function automatic reduced_t reduce_fraction(input field_t numer, input field_t denom);
    word_t    num;
    word_t    den;
    word_t    divisor;
    word_t    step;
    word_t    prev;
    word_t    carry;
    word_t    whole;
    reduced_t res;
    num     = word_t'(numer);
    den     = word_t'(denom);
    step    = den;
    prev    = num;
    divisor = '0;
    whole   = '0;
    // Euclid, seeded with the denominator; stays at zero for a zero denominator.
    while (step != '0) begin
      divisor = step;
      carry   = trunc_rem(prev, divisor);
      prev    = divisor;
      step    = carry;
    end
    if (divisor != '0) begin
      num   = trunc_quot(num, divisor);
      den   = trunc_quot(den, divisor);
      whole = trunc_quot(num, den);
      num   = trunc_rem(num, den);
    end
    res.whole_part     = field_t'(signed'(whole));
    res.rem_numer      = field_t'(signed'(num));
    res.reduced_denom  = field_t'(signed'(den));
    res.common_divisor = field_t'(signed'(divisor));
    return res;
  endfunction

  // Random signed value that fits in width bits, sign-extended to the port width.
  function automatic field_t rand_signed(input int unsigned width);
    logic signed [FIELD_W-1:0] v;
    v = {$urandom(), $urandom()};
    return field_t'((v <<< (FIELD_W - width)) >>> (FIELD_W - width));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Present one beat, hold it until taken, then log what the block now owes.
  // Valid stays high on return so a back-to-back beat needs no extra edge.
  task automatic send_fraction(input field_t numer, input field_t denom,
                               input logic typed_in, input reduced_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    numer_in_i <= numer;
    denom_in_i <= denom;
    do @(posedge clk_i); while (in_stall_o);
    awaited_reductions.push_back(typed_in ? typed_res : reduce_fraction(numer, denom));
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (awaited_reductions.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, drawn fresh each cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic check_field(input string field_name, input field_t want, input field_t got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)", $realtime,
                 field_name, $signed(want), want, $signed(got), got);
    end
  endtask

  // Compare every result beat with the oldest owed reduction, field by field.
  always @(posedge clk_i) begin
    reduced_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reductions.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing owed: whole %0d rem %0d den %0d gcd %0d",
                   $realtime, $signed(whole_part_o), $signed(rem_numer_o),
                   $signed(reduced_denom_o), $signed(common_divisor_o));
      end else begin
        want = awaited_reductions.pop_front();
        check_field("whole_part",     want.whole_part,     whole_part_o);
        check_field("rem_numer",      want.rem_numer,      rem_numer_o);
        check_field("reduced_denom",  want.reduced_denom,  reduced_denom_o);
        check_field("common_divisor", want.common_divisor, common_divisor_o);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    field_t      numer;
    field_t      denom;
    field_t      factor;
    field_t      extreme_vals [6];
    int unsigned pick;
    int unsigned factor_w;

    extreme_vals = '{MOST_NEG, MOST_POS, MINUS_ONE, 64'd0, 64'd1, MOST_NEG + 64'd1};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with the sender at 36 % idle and the receiver at 59 %.
    foreach (DIRECTED_ROWS[i])
      send_fraction(DIRECTED_ROWS[i].numer, DIRECTED_ROWS[i].denom,
                    DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].res);
    hold_until_drained();

    // Three random phases: idle rates as above, then swapped, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 59 : 0;
      rx_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 36 : 0;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // Fraction with a shared factor; keep the products inside 64 bits.
          factor_w = $urandom_range(1, 24);
          factor   = rand_signed(factor_w);
          numer    = rand_signed($urandom_range(1, 63 - factor_w)) * factor;
          denom    = rand_signed($urandom_range(1, 63 - factor_w)) * factor;
        end else if (pick < 70) begin
          numer = {$urandom(), $urandom()};
          denom = {$urandom(), $urandom()};
        end else if (pick < 82) begin
          numer = rand_signed($urandom_range(1, 64));
          denom = rand_signed($urandom_range(1, 64));
        end else if (pick < 88) begin
          numer = {$urandom(), $urandom()};
          denom = '0;
        end else if (pick < 94) begin
          // Exact multiple: the reduced fraction is a plain integer.
          denom = rand_signed($urandom_range(1, 32));
          numer = denom * rand_signed($urandom_range(1, 31));
        end else begin
          numer = extreme_vals[$urandom_range(5)];
          denom = extreme_vals[$urandom_range(5)];
        end
        send_fraction(numer, denom, 1'b0, NO_RESULT);
      end
      hold_until_drained();
    end

    // Let a stray late beat show up before judging.
    repeat (ITEM_CYCLES_MAX) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
